// File: rtl/spw_pkg.sv
`default_nettype none
package spw_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned CfgAddrW  = 6;

  // Register byte addresses (64-bit registers at 8*i).
  localparam logic [CfgAddrW-1:0] AddrMidA   = 6'd0;
  localparam logic [CfgAddrW-1:0] AddrMidB   = 6'd8;
  localparam logic [CfgAddrW-1:0] AddrMidC   = 6'd16;
  localparam logic [CfgAddrW-1:0] AddrMidD   = 6'd24;
  localparam logic [CfgAddrW-1:0] AddrRounds = 6'd32;
  localparam logic [CfgAddrW-1:0] AddrCost   = 6'd40;

  typedef logic [31:0] word_t;

  // One pipeline slot of the compression: working variables and schedule window.
  typedef struct packed {
    logic       vld;
    word_t [7:0] v;
    word_t [15:0] w;
  } rnd_t;

  typedef struct packed {
    logic [255:0] midstate;
    logic [15:0]  rounds;
    logic [7:0]   cost;
  } cfg_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: rtl/spw_if.sv
`default_nettype none
interface spw_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] stamp_upper;
  logic [63:0] stamp_lower;
  modport source (output valid, output stamp_upper, output stamp_lower, input ready);
  modport sink   (input valid, input stamp_upper, input stamp_lower, output ready);
endinterface

interface spw_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] zero_bits;
  logic       meets_cost;
  modport source (output valid, output zero_bits, output meets_cost, input ready);
  modport sink   (input valid, input zero_bits, input meets_cost, output ready);
endinterface
`default_nettype wire

// File: rtl/spw_round.sv
`default_nettype none
// One SHA-256 round with its schedule step, registered at the output.
module spw_round #(
  parameter logic [5:0] Idx = 6'd0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire spw_pkg::rnd_t in_i,
  output spw_pkg::rnd_t      out_o
);
  spw_pkg::rnd_t out_d;
  logic vld_q;
  spw_pkg::word_t [7:0] v_q;
  spw_pkg::word_t [15:0] w_q;
  spw_pkg::word_t t1, t2, a, e, s0, s1, wn;

  always_comb begin
    a  = in_i.v[0];
    e  = in_i.v[4];
    t1 = in_i.v[7] + (spw_pkg::rotr(e, 6) ^ spw_pkg::rotr(e, 11) ^ spw_pkg::rotr(e, 25))
       + ((e & in_i.v[5]) ^ (~e & in_i.v[6])) + spw_pkg::round_k(Idx) + in_i.w[0];
    t2 = (spw_pkg::rotr(a, 2) ^ spw_pkg::rotr(a, 13) ^ spw_pkg::rotr(a, 22))
       + ((a & in_i.v[1]) ^ (a & in_i.v[2]) ^ (in_i.v[1] & in_i.v[2]));
    s0 = spw_pkg::rotr(in_i.w[1], 7) ^ spw_pkg::rotr(in_i.w[1], 18) ^ (in_i.w[1] >> 3);
    s1 = spw_pkg::rotr(in_i.w[14], 17) ^ spw_pkg::rotr(in_i.w[14], 19) ^ (in_i.w[14] >> 10);
    wn = in_i.w[0] + s0 + in_i.w[9] + s1;
    out_d.vld  = in_i.vld;
    out_d.v[0] = t1 + t2;
    out_d.v[1] = in_i.v[0];
    out_d.v[2] = in_i.v[1];
    out_d.v[3] = in_i.v[2];
    out_d.v[4] = in_i.v[3] + t1;
    out_d.v[5] = in_i.v[4];
    out_d.v[6] = in_i.v[5];
    out_d.v[7] = in_i.v[6];
    for (int i = 0; i < 15; i++) out_d.w[i] = in_i.w[i+1];
    out_d.w[15] = wn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= out_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= out_d.v;
      w_q <= out_d.w;
    end
  end

  assign out_o = {vld_q, v_q, w_q};
endmodule
`default_nettype wire

// File: rtl/spw_finish.sv
`default_nettype none
// Adds the midstate, then counts leading zeros over two registered stages.
module spw_finish (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire spw_pkg::rnd_t  in_i,
  input  wire spw_pkg::cfg_t  cfg_i,
  output logic                vld_o,
  output logic [8:0]          zero_bits_o,
  output logic                meets_o
);
  logic vld1_q, vld2_q;
  logic [255:0] dig_q;
  logic [7:0] nz_q;
  logic [7:0][5:0] lz_q;
  logic [7:0] nz_d;
  logic [7:0][5:0] lz_d;
  logic [8:0] zb;
  logic found;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      nz_d[i] = dig_q[255-32*i -: 32] != '0;
      lz_d[i] = 6'd32;
      for (int b = 0; b < 32; b++) begin
        if (dig_q[224-32*i + b]) lz_d[i] = 6'(31 - b);
      end
    end
    zb = 9'd256;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!found && nz_q[i]) begin
        zb = 9'(32*i) + {3'b0, lz_q[i]};
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= in_i.vld;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 8; i++) begin
        dig_q[255-32*i -: 32] <= in_i.v[i] + cfg_i.midstate[255-32*i -: 32];
      end
      nz_q <= nz_d;
      lz_q <= lz_d;
    end
  end

  assign vld_o       = vld2_q;
  assign zero_bits_o = zb;
  assign meets_o     = zb >= {1'b0, cfg_i.cost};
endmodule
`default_nettype wire

// File: rtl/sha256_proof_of_work_stamp_check.sv
`default_nettype none
// Channel  Direction  Payload
// in_if    sink       stamp_upper[63:0], stamp_lower[63:0]
// out_if   source     zero_bits[8:0], meets_cost
// APB      slave      six registers at 8-byte spacing, 64-bit data
//
// One word is accepted every cycle unless the output stalls; each passes through
// 64 round stages plus two finishing stages, then the output register.
// The whole pipeline advances together; when the output register is full and
// not taken, every stage holds, so nothing is lost or repeated.
// Reset clears the valid bits and sets the register reset values.
module sha256_proof_of_work_stamp_check (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spw_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [63:0]                   pwdata,
  output logic [63:0]                        prdata,
  output logic                               pready,
  spw_in_if.sink                             in_if,
  spw_out_if.source                          out_if
);
  spw_pkg::cfg_t cfg_q;
  logic wr;
  logic adv;
  logic fin_vld, fin_meets;
  logic [8:0] fin_zb;
  logic ovld_q, omeets_q;
  logic [8:0] ozb_q;
  logic [63:0] bits;
  spw_pkg::rnd_t head;
  spw_pkg::rnd_t stage [64];

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.midstate <= '0;
      cfg_q.rounds   <= 16'd1;
      cfg_q.cost     <= 8'd8;
    end else if (wr) begin
      unique case (paddr)
        spw_pkg::AddrMidA:   cfg_q.midstate[255:192] <= pwdata;
        spw_pkg::AddrMidB:   cfg_q.midstate[191:128] <= pwdata;
        spw_pkg::AddrMidC:   cfg_q.midstate[127:64]  <= pwdata;
        spw_pkg::AddrMidD:   cfg_q.midstate[63:0]    <= pwdata;
        spw_pkg::AddrRounds: cfg_q.rounds            <= pwdata[15:0];
        spw_pkg::AddrCost:   cfg_q.cost              <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      spw_pkg::AddrMidA:   prdata = cfg_q.midstate[255:192];
      spw_pkg::AddrMidB:   prdata = cfg_q.midstate[191:128];
      spw_pkg::AddrMidC:   prdata = cfg_q.midstate[127:64];
      spw_pkg::AddrMidD:   prdata = cfg_q.midstate[63:0];
      spw_pkg::AddrRounds: prdata = {48'b0, cfg_q.rounds};
      spw_pkg::AddrCost:   prdata = {56'b0, cfg_q.cost};
      default:             prdata = '0;
    endcase
  end

  // Whole pipeline moves when the output register is empty or being emptied.
  assign adv = !ovld_q || out_if.ready;
  assign in_if.ready = adv;

  // Message length in bits: (256*rounds + 16) * 8 = rounds*2048 + 128.
  assign bits = {37'b0, cfg_q.rounds, 11'b0} + 64'd128;

  always_comb begin
    head.vld = in_if.valid;
    for (int i = 0; i < 8; i++) head.v[i] = cfg_q.midstate[255-32*i -: 32];
    head.w = '0;
    head.w[0] = in_if.stamp_upper[63:32];
    head.w[1] = in_if.stamp_upper[31:0];
    head.w[2] = in_if.stamp_lower[63:32];
    head.w[3] = in_if.stamp_lower[31:0];
    head.w[4] = 32'h8000_0000;
    head.w[14] = bits[63:32];
    head.w[15] = bits[31:0];
  end

  for (genvar g = 0; g < spw_pkg::NumRounds; g++) begin : g_rnd
    if (g == 0) begin : g_first
      spw_round #(.Idx(6'(g))) u_round (
        .clk_i, .rst_ni, .en_i(adv), .in_i(head), .out_o(stage[g])
      );
    end else begin : g_next
      spw_round #(.Idx(6'(g))) u_round (
        .clk_i, .rst_ni, .en_i(adv), .in_i(stage[g-1]), .out_o(stage[g])
      );
    end
  end

  spw_finish u_finish (
    .clk_i, .rst_ni, .en_i(adv), .in_i(stage[63]), .cfg_i(cfg_q),
    .vld_o(fin_vld), .zero_bits_o(fin_zb), .meets_o(fin_meets)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= fin_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ozb_q    <= fin_zb;
      omeets_q <= fin_meets;
    end
  end

  assign out_if.valid      = ovld_q;
  assign out_if.zero_bits  = ozb_q;
  assign out_if.meets_cost = omeets_q;
endmodule
`default_nettype wire

// File: rtl/spw_checker.sv
`default_nettype none
module spw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [8:0] zero_bits_i,
  input wire logic       meets_cost_i
);
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> zero_bits_i <= 9'd256) else $error("zero count out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(zero_bits_i)
      && $stable(meets_cost_i))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input blocked with empty output");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("input taken during stall");
endmodule

bind sha256_proof_of_work_stamp_check spw_checker u_spw_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .zero_bits_i(out_if.zero_bits),
  .meets_cost_i(out_if.meets_cost)
);
`default_nettype wire
